[hw/rtl/hsi_to_rgb_converter_core_macros.svh]
// ---------------------------------------------------------------------------
// hsi to rgb converter assertion macros
// concurrent assertion helpers, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef HSI_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSI_TO_RGB_CONVERTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define HSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define HSI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HSI_ASSERT(lbl, prop, msg)
`define HSI_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/hsi2rgb_pkg.sv]
// ---------------------------------------------------------------------------
// hsi2rgb_pkg
// shared types, constants and the q30 cosine used to build the ratio table
// ---------------------------------------------------------------------------
package hsi2rgb_pkg;

  localparam int HUE_W   = 11;
  localparam int FRAC_IN_W = 9;   // saturation and intensity
  localparam int LEVEL_W = 8;
  localparam int I255_W  = 16;    // intensity times 255

  localparam logic [FRAC_IN_W-1:0] FULL_SCALE = 9'd256;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX  = 8'd255;

  localparam longint unsigned Q30_ONE           = 64'd1073741824;
  localparam longint unsigned Q30_PI_THIRD      = 64'd1124419809;
  localparam longint unsigned Q30_TWO_PI_THIRDS = 64'd2248839618;

  // which 120 degree sector the hue falls in
  typedef enum logic [1:0] {
    SECTOR_RG = 2'd0,
    SECTOR_GB = 2'd1,
    SECTOR_BR = 2'd2
  } sector_e;

  // unsigned 64-bit quotient by shift and subtract, used only for constant tables
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q30 cosine, alternating taylor sum, truncating at every step
  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = Q30_ONE;
    sum  = longint'(Q30_ONE);
    for (int unsigned n = 1; n <= 14; n++) begin
      term = (term * x2) >> 30;
      term = udiv64(term, 64'((2 * n - 1) * (2 * n)));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

endpackage

[hw/rtl/hsi_to_rgb_converter_core.sv]
// ---------------------------------------------------------------------------
// hsi_to_rgb_converter_core
// pipelined hue, saturation, intensity to 8-bit rgb conversion
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------
//  request  | in        | start_i, busy_o  | hue_i, saturation_i, intensity_i
//  result   | out       | done_o (strobe)  | red_o, green_o, blue_o
//
//  one request may enter every cycle; busy_o stays low, the pipe never stalls
//  each result shows on the outputs for one cycle; nine register stages lie
//  between the request and its result (request register, hue reduction
//  multiply, remainder, sector split, ratio table read, saturation multiply,
//  share sums, intensity multiply, level clamp)
//  reset clears only the valid bits; data registers carry no reset
//
`include "hsi_to_rgb_converter_core_macros.svh"

module hsi_to_rgb_converter_core import hsi2rgb_pkg::*; #(
  parameter int SECTOR_STEPS  = 512,
  parameter int FRACTION_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [HUE_W-1:0]     hue_i,
  input  logic [FRAC_IN_W-1:0] saturation_i,
  input  logic [FRAC_IN_W-1:0] intensity_i,
  output logic                 done_o,
  output logic [LEVEL_W-1:0]   red_o,
  output logic [LEVEL_W-1:0]   green_o,
  output logic [LEVEL_W-1:0]   blue_o
);

  // hue reduction modulo three sectors by reciprocal multiply
  localparam int D3    = 3 * SECTOR_STEPS;
  localparam int SH    = 24;
  localparam int M3    = (1 << SH) / D3;
  localparam int M3_W  = $clog2(M3 + 1);
  localparam int PROD_W = HUE_W + M3_W;
  localparam int MAXQ  = ((1 << HUE_W) - 1) / D3;
  localparam int Q3_W  = $clog2(MAXQ + 2);
  localparam int K_W   = (SECTOR_STEPS > 1) ? $clog2(SECTOR_STEPS) : 1;

  // ratio cos(h)/cos(60deg-h), range -1..2
  localparam int RATIO_W = FRACTION_BITS + 3;
  localparam int SR_W    = RATIO_W + 10;
  localparam int POS_W   = FRACTION_BITS + 10;
  localparam int PRODC_W = I255_W + POS_W;
  localparam int LAT     = 9;

  typedef logic signed [RATIO_W-1:0] ratio_rom_t [SECTOR_STEPS];

  // table entry for step k, q(FRACTION_BITS), rounded half away from zero
  function automatic logic signed [RATIO_W-1:0] ratio_at(input int k);
    longint unsigned x;
    longint unsigned d;
    longint          num;
    longint          den;
    longint unsigned mag;
    longint unsigned q;
    x = udiv64(longint'(k) * Q30_TWO_PI_THIRDS, 64'(SECTOR_STEPS));
    d = (x <= Q30_PI_THIRD) ? (Q30_PI_THIRD - x) : (x - Q30_PI_THIRD);
    num = cos_q30(x);
    den = cos_q30(d);
    if (den <= 0) begin
      den = 1;
    end
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = udiv64((mag << FRACTION_BITS) + (longint'(den) >> 1), 64'(den));
    return (num < 0) ? RATIO_W'(-longint'(q)) : RATIO_W'(q);
  endfunction

  function automatic ratio_rom_t build_rom();
    ratio_rom_t rom;
    for (int k = 0; k < SECTOR_STEPS; k++) begin
      rom[k] = ratio_at(k);
    end
    return rom;
  endfunction

  localparam ratio_rom_t RATIO_ROM = build_rom();

  localparam logic signed [SR_W-1:0] ONE_S = SR_W'(FULL_SCALE) <<< FRACTION_BITS;

  // output level: drop the fraction, clamp to 255
  function automatic logic [LEVEL_W-1:0] clip_level(input logic [PRODC_W-1:0] p);
    logic [PRODC_W-1:0] v;
    v = p >> (I255_W + FRACTION_BITS);
    return (v > PRODC_W'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
  endfunction

  // valid bits, one per stage
  logic [LAT-1:0] vld_q, vld_d;

  // stage 1: request register with clamps
  logic [HUE_W-1:0]     hue1_q;
  logic [FRAC_IN_W-1:0] sat1_q, int1_q;
  // stage 2: hue times reciprocal
  logic [PROD_W-1:0]    rcp2_q;
  logic [HUE_W-1:0]     hue2_q;
  logic [FRAC_IN_W-1:0] sat2_q;
  logic [I255_W-1:0]    i2_q;
  // stage 3: raw remainder
  logic [HUE_W-1:0]     rem3_q;
  logic [FRAC_IN_W-1:0] sat3_q;
  logic [I255_W-1:0]    i3_q;
  // stage 4: sector and step
  sector_e              sec4_q;
  logic [K_W-1:0]       step4_q;
  logic [FRAC_IN_W-1:0] sat4_q;
  logic [I255_W-1:0]    i4_q;
  // stage 5: ratio
  sector_e              sec5_q;
  logic signed [RATIO_W-1:0] ratio5_q;
  logic [FRAC_IN_W-1:0] sat5_q;
  logic [I255_W-1:0]    i5_q;
  // stage 6: s times ratio
  sector_e              sec6_q;
  logic signed [SR_W-1:0] sr6_q;
  logic [FRAC_IN_W-1:0] sat6_q;
  logic [I255_W-1:0]    i6_q;
  // stage 7: shares clipped at zero
  sector_e              sec7_q;
  logic [POS_W-1:0]     a7_q, b7_q, c7_q;
  logic [I255_W-1:0]    i7_q;
  // stage 8: intensity products
  sector_e              sec8_q;
  logic [PRODC_W-1:0]   pa8_q, pb8_q, pc8_q;
  // stage 9: outputs
  logic [LEVEL_W-1:0]   red_q, green_q, blue_q;

  // combinational intermediates
  logic                 accept;
  logic [Q3_W-1:0]      q3;
  logic [HUE_W-1:0]     rem_fix;
  sector_e              sec_d;
  logic [K_W-1:0]       step_d;
  logic signed [SR_W-1:0] sat_ext, ratio_ext;
  logic signed [SR_W-1:0] share_b, share_c;
  logic [POS_W-1:0]     share_a;
  logic [LEVEL_W-1:0]   lvl_a, lvl_b, lvl_c;
  logic [LEVEL_W-1:0]   red_d, green_d, blue_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign vld_d = {vld_q[LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // hue reduction: quotient estimate is exact or one low
  assign q3 = Q3_W'(rcp2_q >> SH);

  always_comb begin
    rem_fix = (int'(rem3_q) >= D3) ? (rem3_q - HUE_W'(D3)) : rem3_q;
    if (int'(rem_fix) >= 2 * SECTOR_STEPS) begin
      sec_d  = SECTOR_BR;
      step_d = K_W'(int'(rem_fix) - 2 * SECTOR_STEPS);
    end else if (int'(rem_fix) >= SECTOR_STEPS) begin
      sec_d  = SECTOR_GB;
      step_d = K_W'(int'(rem_fix) - SECTOR_STEPS);
    end else begin
      sec_d  = SECTOR_RG;
      step_d = K_W'(rem_fix);
    end
  end

  // tripled shares in q(8+FRACTION_BITS)
  assign sat_ext   = SR_W'($signed({1'b0, sat5_q}));
  assign ratio_ext = SR_W'(ratio5_q);
  assign share_a   = POS_W'(FULL_SCALE - sat6_q) << FRACTION_BITS;
  assign share_b   = ONE_S + sr6_q;
  assign share_c   = ((SR_W'(FULL_SCALE) + SR_W'(sat6_q)) <<< FRACTION_BITS) - sr6_q;

  assign lvl_a = clip_level(pa8_q);
  assign lvl_b = clip_level(pb8_q);
  assign lvl_c = clip_level(pc8_q);

  // sector decides which share drives which channel
  always_comb begin
    case (sec8_q)
      SECTOR_RG: begin
        red_d = lvl_b; green_d = lvl_c; blue_d = lvl_a;
      end
      SECTOR_GB: begin
        red_d = lvl_a; green_d = lvl_b; blue_d = lvl_c;
      end
      SECTOR_BR: begin
        red_d = lvl_c; green_d = lvl_a; blue_d = lvl_b;
      end
      default: begin
        red_d = lvl_b; green_d = lvl_c; blue_d = lvl_a;
      end
    endcase
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    // stage 1
    hue1_q <= hue_i;
    sat1_q <= (saturation_i > FULL_SCALE) ? FULL_SCALE : saturation_i;
    int1_q <= (intensity_i > FULL_SCALE) ? FULL_SCALE : intensity_i;
    // stage 2
    rcp2_q <= PROD_W'(hue1_q) * PROD_W'(M3);
    hue2_q <= hue1_q;
    sat2_q <= sat1_q;
    i2_q   <= I255_W'({int1_q, 8'd0}) - I255_W'(int1_q);
    // stage 3
    rem3_q <= hue2_q - HUE_W'(int'(q3) * D3);
    sat3_q <= sat2_q;
    i3_q   <= i2_q;
    // stage 4
    sec4_q  <= sec_d;
    step4_q <= step_d;
    sat4_q  <= sat3_q;
    i4_q    <= i3_q;
    // stage 5
    sec5_q   <= sec4_q;
    ratio5_q <= RATIO_ROM[step4_q];
    sat5_q   <= sat4_q;
    i5_q     <= i4_q;
    // stage 6
    sec6_q <= sec5_q;
    sr6_q  <= sat_ext * ratio_ext;
    sat6_q <= sat5_q;
    i6_q   <= i5_q;
    // stage 7
    sec7_q <= sec6_q;
    a7_q   <= share_a;
    b7_q   <= (share_b > 0) ? POS_W'(share_b) : '0;
    c7_q   <= (share_c > 0) ? POS_W'(share_c) : '0;
    i7_q   <= i6_q;
    // stage 8
    sec8_q <= sec7_q;
    pa8_q  <= PRODC_W'(i7_q) * PRODC_W'(a7_q);
    pb8_q  <= PRODC_W'(i7_q) * PRODC_W'(b7_q);
    pc8_q  <= PRODC_W'(i7_q) * PRODC_W'(c7_q);
    // stage 9
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = vld_q[LAT-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // every result comes from an earlier accepted request
  `HSI_ASSERT(a_done_from_req, done_o |-> $past(accept, LAT), "result without request")
  // reduced hue always lands inside one sector
  `HSI_ASSERT_NEVER(a_step_range, vld_q[3] && (int'(step4_q) >= SECTOR_STEPS),
                    "sector step out of range")
  // zero saturation gives grey
  `HSI_ASSERT(a_grey, (done_o && $past(accept && (saturation_i == '0), LAT)) |->
              (red_o == green_o && green_o == blue_o), "grey request not grey")
  // zero intensity gives black
  `HSI_ASSERT(a_black, (done_o && $past(accept && (intensity_i == '0), LAT)) |->
              (red_o == '0 && green_o == '0 && blue_o == '0), "dark request not black")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hsi to rgb converter core testbench
// drives hue, saturation, intensity requests through the command handshake,
// predicts each rgb result with a fixed point model of its own and compares
// every done_o strobe against the oldest outstanding prediction
// ---------------------------------------------------------------------------
module tb_top;
  import hsi2rgb_pkg::*;

  localparam int SECTOR_STEPS  = 512;
  localparam int FRACTION_BITS = 12;

  typedef longint unsigned u64_t;

  // q30 angle constants for the ratio table
  localparam u64_t ANGLE_ONE = 64'd1073741824;
  localparam u64_t ANGLE_60  = 64'd1124419809;
  localparam u64_t ANGLE_120 = 64'd2248839618;
  localparam u64_t UNIT      = 64'd256;     // 1.0 for saturation and intensity

  // raw field ranges
  localparam int HUE_MAX_RAW  = (1 << HUE_W) - 1;
  localparam int FRAC_MAX_RAW = (1 << FRAC_IN_W) - 1;
  localparam int HUE_PERIOD   = 3 * SECTOR_STEPS;

  localparam int RANDOM_REQUESTS = 1530;
  localparam int PHASE_LEN       = 520;     // requests per idling phase
  localparam int DRAIN_CYCLES    = 30;      // pipe is nine stages deep
  localparam int SHOW_LIMIT      = 10;

  typedef struct packed {
    logic [HUE_W-1:0]     hue;
    logic [FRAC_IN_W-1:0] sat;
    logic [FRAC_IN_W-1:0] lum;
  } pixel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    pixel_t px;
    rgb_t   rgb;
  } rgb_expect_t;

  // dut signals; the driven inputs are known from time zero
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start_i      = 1'b0;
  logic                 busy_o;
  logic [HUE_W-1:0]     hue_i        = '0;
  logic [FRAC_IN_W-1:0] saturation_i = '0;
  logic [FRAC_IN_W-1:0] intensity_i  = '0;
  logic                 done_o;
  logic [LEVEL_W-1:0]   red_o;
  logic [LEVEL_W-1:0]   green_o;
  logic [LEVEL_W-1:0]   blue_o;

  pixel_t      pixel_q[$];          // requests not yet driven
  rgb_expect_t rgb_expected_q[$];   // predicted colors waiting for done_o
  pixel_t      next_pixel;
  rgb_expect_t got_entry;
  int          requests_sent = 0;
  int          error_count   = 0;

  hsi_to_rgb_converter_core #(
    .SECTOR_STEPS (SECTOR_STEPS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .intensity_i (intensity_i),
    .done_o      (done_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // color predictor
  // ------------------------------------------------------------------------

  // q30 cosine as a truncating alternating taylor series, fifteen terms
  function automatic longint taylor_cos(input u64_t angle);
    u64_t   sq;
    u64_t   term;
    longint acc;
    sq   = (angle * angle) >> 30;
    term = ANGLE_ONE;
    acc  = longint'(ANGLE_ONE);
    for (u64_t n = 1; n <= 14; n++) begin
      term = (term * sq) >> 30;
      term = term / ((2 * n - 1) * (2 * n));
      if (n[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // cos(h) / cos(60deg - h) for one step of a sector, q(FRACTION_BITS),
  // magnitude rounded half away from zero, sign of cos(h)
  function automatic longint cos_ratio(input u64_t step);
    u64_t   ang;
    u64_t   mirror;
    u64_t   mag;
    u64_t   quot;
    longint num;
    longint den;
    ang    = (step * ANGLE_120) / u64_t'(SECTOR_STEPS);
    mirror = (ang <= ANGLE_60) ? (ANGLE_60 - ang) : (ang - ANGLE_60);
    num    = taylor_cos(ang);
    den    = taylor_cos(mirror);
    if (den <= 0) begin
      den = 1;
    end
    mag  = (num < 0) ? u64_t'(-num) : u64_t'(num);
    quot = ((mag << FRACTION_BITS) + (u64_t'(den) >> 1)) / u64_t'(den);
    return (num < 0) ? -longint'(quot) : longint'(quot);
  endfunction

  // one channel: intensity * 255 * share, truncated and clamped
  function automatic logic [LEVEL_W-1:0] channel_level(input u64_t lum, input longint share);
    u64_t v;
    if (share <= 0) begin
      return '0;
    end
    v = (lum * 255 * u64_t'(share)) >> (16 + FRACTION_BITS);
    return (v > 255) ? LEVEL_MAX : v[LEVEL_W-1:0];
  endfunction

  function automatic rgb_t hsi_to_rgb(input pixel_t px);
    u64_t    sat;
    u64_t    lum;
    u64_t    wrapped;
    longint  s_times_r;
    longint  share_min;
    longint  share_up;
    longint  share_rest;
    sector_e sector;
    rgb_t    rgb;
    rgb       = '0;
    // anything above 1.0 counts as 1.0
    sat       = (px.sat > FULL_SCALE) ? UNIT : u64_t'(px.sat);
    lum       = (px.lum > FULL_SCALE) ? UNIT : u64_t'(px.lum);
    wrapped   = u64_t'(px.hue) % HUE_PERIOD;
    sector    = sector_e'(wrapped / SECTOR_STEPS);
    s_times_r = longint'(sat) * cos_ratio(wrapped % SECTOR_STEPS);
    share_min  = longint'(UNIT - sat) << FRACTION_BITS;
    share_up   = (longint'(UNIT) << FRACTION_BITS) + s_times_r;
    share_rest = (longint'(UNIT + sat) << FRACTION_BITS) - s_times_r;
    case (sector)
      SECTOR_RG: begin
        rgb.red   = channel_level(lum, share_up);
        rgb.green = channel_level(lum, share_rest);
        rgb.blue  = channel_level(lum, share_min);
      end
      SECTOR_GB: begin
        rgb.red   = channel_level(lum, share_min);
        rgb.green = channel_level(lum, share_up);
        rgb.blue  = channel_level(lum, share_rest);
      end
      SECTOR_BR: begin
        rgb.red   = channel_level(lum, share_rest);
        rgb.green = channel_level(lum, share_min);
        rgb.blue  = channel_level(lum, share_up);
      end
      default: begin
        rgb = '0;
      end
    endcase
    return rgb;
  endfunction

  // ------------------------------------------------------------------------
  // driver
  // ------------------------------------------------------------------------

  // sender idling per phase: light, then heavy, then none at all
  function automatic int gap_percent(input int sent);
    if (sent < PHASE_LEN) begin
      return 17;
    end else if (sent < 2 * PHASE_LEN) begin
      return 63;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i      <= 1'b0;
      hue_i        <= '0;
      saturation_i <= '0;
      intensity_i  <= '0;
    end else if (!(start_i && busy_o)) begin
      // a request held with busy low is taken at this edge
      if (start_i) begin
        rgb_expected_q.push_back('{
          px:  '{hue: hue_i, sat: saturation_i, lum: intensity_i},
          rgb: hsi_to_rgb('{hue: hue_i, sat: saturation_i, lum: intensity_i})
        });
        requests_sent++;
      end
      // one assignment to start_i per edge, so back to back requests stay high
      if (pixel_q.size() != 0 && $urandom_range(99) >= gap_percent(requests_sent)) begin
        next_pixel   = pixel_q.pop_front();
        start_i      <= 1'b1;
        hue_i        <= next_pixel.hue;
        saturation_i <= next_pixel.sat;
        intensity_i  <= next_pixel.lum;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (rgb_expected_q.size() == 0) begin
          if (error_count < SHOW_LIMIT) begin
            $display("unexpected result r %0d g %0d b %0d", red_o, green_o, blue_o);
          end
          error_count++;
        end else begin
          got_entry = rgb_expected_q.pop_front();
          if (red_o !== got_entry.rgb.red || green_o !== got_entry.rgb.green ||
              blue_o !== got_entry.rgb.blue) begin
            if (error_count < SHOW_LIMIT) begin
              $display("mismatch h %0d s %0d i %0d exp %0d %0d %0d got %0d %0d %0d",
                       got_entry.px.hue, got_entry.px.sat, got_entry.px.lum,
                       got_entry.rgb.red, got_entry.rgb.green, got_entry.rgb.blue,
                       red_o, green_o, blue_o);
            end
            error_count++;
          end
        end
      end else if (done_o !== 1'b0) begin
        // unknown strobe is a failure on its own
        if (error_count < SHOW_LIMIT) begin
          $display("done_o unknown");
        end
        error_count++;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------------

  task automatic queue_pixel(input int hue, input int sat, input int lum);
    pixel_q.push_back('{hue: hue[HUE_W-1:0], sat: sat[FRAC_IN_W-1:0],
                        lum: lum[FRAC_IN_W-1:0]});
  endtask

  initial begin
    int roll;
    int sat;

    // directed: grey, sector edges, wrapped hue, clamped inputs
    queue_pixel(0, 0, 0);
    queue_pixel(0, 0, 256);                       // zero saturation, full white
    queue_pixel(700, 0, 128);                     // zero saturation, mid grey
    queue_pixel(0, 256, 256);
    queue_pixel(SECTOR_STEPS - 1, 256, 256);      // share near zero at sector end
    queue_pixel(SECTOR_STEPS, 256, 256);
    queue_pixel(2 * SECTOR_STEPS - 1, 256, 256);
    queue_pixel(2 * SECTOR_STEPS, 256, 256);
    queue_pixel(HUE_PERIOD - 1, 256, 256);
    queue_pixel(HUE_PERIOD, 256, 256);            // hue wraps back to red
    queue_pixel(HUE_MAX_RAW, 200, 180);           // largest raw hue
    queue_pixel(256, 256, 256);                   // ratio at 60 degrees
    queue_pixel(170, 256, 256);                   // rising share above 255
    queue_pixel(384, 256, 256);                   // cosine crosses zero
    queue_pixel(450, 256, 256);                   // negative ratio
    queue_pixel(1200, 128, 200);
    queue_pixel(300, FRAC_MAX_RAW, FRAC_MAX_RAW); // both clamped to 1.0
    queue_pixel(900, 257, 257);
    queue_pixel(1000, 1, 1);
    queue_pixel(100, 255, 255);
    queue_pixel(1400, 256, 0);                    // black at full saturation

    // random: mostly legal fields, some edges, some raw out-of-range values
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        queue_pixel($urandom_range(HUE_MAX_RAW), $urandom_range(FRAC_MAX_RAW),
                    $urandom_range(FRAC_MAX_RAW));
      end else if (roll < 25) begin
        case ($urandom_range(3))
          0:       sat = 0;
          1:       sat = 1;
          2:       sat = 255;
          default: sat = 256;
        endcase
        queue_pixel($urandom_range(HUE_PERIOD - 1), sat,
                    ($urandom_range(1) != 0) ? 256 : $urandom_range(256));
      end else begin
        queue_pixel($urandom_range(HUE_PERIOD - 1), $urandom_range(256),
                    $urandom_range(256));
      end
    end

    // single reset at the start of the run
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests taken, then every prediction checked, then a drain window
    while (pixel_q.size() != 0 || start_i) begin
      @(negedge clk_i);
    end
    while (rgb_expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_count == 0 && rgb_expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[hsi_to_rgb_converter_core.f]
+incdir+hw/rtl
hw/rtl/hsi2rgb_pkg.sv
hw/rtl/hsi_to_rgb_converter_core.sv
sim/tb_top.sv
